FILE: rtl/grid_pll_lock_detector_core_assert.svh
// Assertion macros for the lock detector checker.
`ifndef GRID_PLL_LOCK_DETECTOR_CORE_ASSERT_SVH
`define GRID_PLL_LOCK_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GPLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lock detector check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GPLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lock detector check failed");

`endif

FILE: rtl/gpld_pkg.sv
// Types, constants and status codes for the grid PLL lock detector.
package gpld_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int CMP_WIDTH       = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 2;
  localparam int PROD_WIDTH      = SAMPLE_WIDTH + 6;
  localparam int INDEX_WIDTH     = 17;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_LOCKED  = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_Q_LOCK_MAX    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D_LOCK_MIN    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D_LOCK_MAX    = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH = 2'd3;

  localparam logic [14:0]        RST_Q_LOCK_MAX    = 15'd1000;
  localparam logic signed [15:0] RST_D_LOCK_MIN    = 16'sd0;
  localparam logic signed [15:0] RST_D_LOCK_MAX    = 16'sd32767;
  localparam logic [15:0]        RST_WINDOW_LENGTH = 16'd1000;

  typedef struct packed {
    sample_t d_sample;
    sample_t q_sample;
    sample_t phase_a_sample;
  } in_t;

  typedef struct packed {
    logic [1:0] lock_status;
    logic       window_closed;
  } out_t;

  typedef struct packed {
    logic [14:0]        q_lock_max;
    logic signed [15:0] d_lock_min;
    logic signed [15:0] d_lock_max;
    logic [15:0]        window_length;
  } cfg_t;

endpackage

FILE: rtl/grid_pll_lock_detector_core.sv
// Top level of the grid PLL lock detector: channel registers and configuration.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    gpld_pkg::in_t, one grid sample
//   out_     output     out_valid / out_stall  gpld_pkg::out_t, status after the sample
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample is taken per cycle unless in_stall is high; the sample is held in the
// input register; the evaluation between it and the result register sets the rate.
// Synchronous active-low reset restores the register defaults and the invalid state.
// While out_stall holds a result, one more sample can still be taken into the input
// register before in_stall rises.
module grid_pll_lock_detector_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  gpld_pkg::in_t                            in_data,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output gpld_pkg::out_t                           out_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [gpld_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [gpld_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

  logic           s1_valid_r, s1_valid_nxt;
  gpld_pkg::in_t  s1_data_r;
  logic           out_valid_r, out_valid_nxt;
  gpld_pkg::out_t out_data_r;
  gpld_pkg::cfg_t cfg_r;
  gpld_pkg::out_t result;
  logic           advance, step;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  gpld_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (s1_data_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.q_lock_max    <= gpld_pkg::RST_Q_LOCK_MAX;
      cfg_r.d_lock_min    <= gpld_pkg::RST_D_LOCK_MIN;
      cfg_r.d_lock_max    <= gpld_pkg::RST_D_LOCK_MAX;
      cfg_r.window_length <= gpld_pkg::RST_WINDOW_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gpld_pkg::REG_Q_LOCK_MAX:    cfg_r.q_lock_max    <= cfg_data[14:0];
        gpld_pkg::REG_D_LOCK_MIN:    cfg_r.d_lock_min    <= cfg_data;
        gpld_pkg::REG_D_LOCK_MAX:    cfg_r.d_lock_max    <= cfg_data;
        gpld_pkg::REG_WINDOW_LENGTH: cfg_r.window_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/gpld_tracker.sv
// Window tracking and lock status logic, with the window and status registers.
module gpld_tracker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  gpld_pkg::in_t  sample,
  input  gpld_pkg::cfg_t cfg,
  output gpld_pkg::out_t result
);

  localparam int W  = gpld_pkg::SAMPLE_WIDTH;
  localparam int CW = gpld_pkg::CMP_WIDTH;
  localparam int PW = gpld_pkg::PROD_WIDTH;
  localparam int IW = gpld_pkg::INDEX_WIDTH;

  logic [1:0]          status_r, status_nxt;
  logic [IW-1:0]       index_r, index_nxt;
  logic [W-1:0]        q_peak_r, q_peak_nxt;
  logic signed [W-1:0] d_low_r, d_low_nxt;
  logic signed [W-1:0] d_high_r, d_high_nxt;

  logic signed [W-1:0]  d_in;
  logic [W-1:0]         q_bits, a_bits, d_bits;
  logic [W-1:0]         abs_q, abs_a;
  logic [W-1:0]         q_pk;
  logic signed [W-1:0]  d_lo, d_hi;
  logic [IW-1:0]        index_inc;
  logic signed [15:0]   dmin, dmax;
  logic signed [CW-1:0] d_lo_x, d_hi_x, dmin_x, dmax_x;
  logic [CW-1:0]        q_pk_x, qmax_x, q2max_x;
  logic [PW-1:0]        a40;
  logic                 bound_broken, bound_inside, phase_ok, closed, clear;
  logic [1:0]           st_a, st_b;
  logic [IW-1:0]        index_a;

  assign d_in   = sample.d_sample;
  assign q_bits = sample.q_sample;
  assign a_bits = sample.phase_a_sample;
  assign d_bits = sample.d_sample;
  assign dmin   = cfg.d_lock_min;
  assign dmax   = cfg.d_lock_max;

  // The most negative sample maps to 2^(W-1), which still fits W unsigned bits.
  assign abs_q = q_bits[W-1] ? (~q_bits + 1'b1) : q_bits;
  assign abs_a = a_bits[W-1] ? (~a_bits + 1'b1) : a_bits;

  assign q_pk      = (abs_q > q_peak_r) ? abs_q : q_peak_r;
  assign d_lo      = (d_in < d_low_r) ? d_in : d_low_r;
  assign d_hi      = (d_in > d_high_r) ? d_in : d_high_r;
  assign index_inc = index_r + 1'b1;

  assign d_lo_x  = CW'(d_lo);
  assign d_hi_x  = CW'(d_hi);
  assign dmin_x  = CW'(dmin);
  assign dmax_x  = CW'(dmax);
  assign q_pk_x  = CW'(q_pk);
  assign qmax_x  = CW'(cfg.q_lock_max);
  assign q2max_x = CW'({cfg.q_lock_max, 1'b0});

  assign bound_broken = (q_pk_x > q2max_x) || (d_lo_x < dmin_x) || (d_hi_x > dmax_x);
  assign bound_inside = (q_pk_x < qmax_x) && (d_lo_x > dmin_x) && (d_hi_x < dmax_x);

  // 40*|a| as two shifts and an add; a negative d can never pass.
  assign a40      = (PW'(abs_a) << 5) + (PW'(abs_a) << 3);
  assign phase_ok = !d_bits[W-1] && (a40 < PW'(d_bits));

  always_comb begin
    st_a    = status_r;
    index_a = index_inc;
    clear   = 1'b0;
    if (status_r == gpld_pkg::ST_LOCKED && bound_broken) begin
      st_a    = gpld_pkg::ST_INVALID;
      index_a = '0;
      clear   = 1'b1;
    end
    closed = (index_a > {1'b0, cfg.window_length});
    st_b   = st_a;
    if (closed) begin
      clear = 1'b1;
      if (st_a != gpld_pkg::ST_LOCKED) begin
        st_b = bound_inside ? gpld_pkg::ST_PENDING : gpld_pkg::ST_INVALID;
      end
    end
    status_nxt = st_b;
    if (st_b == gpld_pkg::ST_PENDING && phase_ok) begin
      status_nxt = gpld_pkg::ST_LOCKED;
    end
    if (clear) begin
      index_nxt  = '0;
      q_peak_nxt = '0;
      d_low_nxt  = gpld_pkg::SAMPLE_MAX;
      d_high_nxt = gpld_pkg::SAMPLE_MIN;
    end else begin
      index_nxt  = index_a;
      q_peak_nxt = q_pk;
      d_low_nxt  = d_lo;
      d_high_nxt = d_hi;
    end
  end

  assign result.lock_status   = status_nxt;
  assign result.window_closed = closed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= gpld_pkg::ST_INVALID;
      index_r  <= '0;
      q_peak_r <= '0;
      d_low_r  <= gpld_pkg::SAMPLE_MAX;
      d_high_r <= gpld_pkg::SAMPLE_MIN;
    end else if (step) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
      q_peak_r <= q_peak_nxt;
      d_low_r  <= d_low_nxt;
      d_high_r <= d_high_nxt;
    end
  end

endmodule

FILE: rtl/gpld_checker.sv
// Port-level checker for the lock detector, bound to the top level.
`include "grid_pll_lock_detector_core_assert.svh"

module gpld_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input gpld_pkg::out_t out_data
);

  logic [1:0] pending_r, pending_nxt;
  logic       last_locked_r, last_locked_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_nxt = pending_r - 1'b1;
    end
    last_locked_nxt = last_locked_r;
    if (out_xfer) begin
      last_locked_nxt = (out_data.lock_status == gpld_pkg::ST_LOCKED);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= '0;
      last_locked_r <= 1'b0;
    end else begin
      pending_r     <= pending_nxt;
      last_locked_r <= last_locked_nxt;
    end
  end

  // A stalled result must be held unchanged.
  `GPLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // Only the input register and the result register can hold samples.
  `GPLD_ASSERT_NOW(a_occupancy, 1'b1, pending_r != 2'd3)
  // A locked state either holds or drops to invalid; it never goes back to pending.
  `GPLD_ASSERT_NOW(a_no_relock_pending, out_xfer && last_locked_r,
                   out_data.lock_status != gpld_pkg::ST_PENDING)
  // The spare status code is never reported.
  `GPLD_ASSERT_NOW(a_status_code, out_valid, out_data.lock_status != gpld_pkg::ST_UNUSED)

endmodule

bind grid_pll_lock_detector_core gpld_checker u_gpld_checker (.*);
